>>> src/alarm_burst_tone_sequencer_unit_defines.svh
// ----------------------------------------------------------------------------
// Alarm burst tone sequencer - assertion macros
// Shared concurrent assertion forms, clocked on i_clk and off during reset.
// ----------------------------------------------------------------------------
`ifndef ALARM_BURST_TONE_SEQUENCER_UNIT_DEFINES_SVH
`define ALARM_BURST_TONE_SEQUENCER_UNIT_DEFINES_SVH

// Same-cycle implication.
`define ABTS_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("abts: same-cycle check failed");

// Next-cycle implication.
`define ABTS_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("abts: next-cycle check failed");

`endif

>>> src/abts_pkg.sv
// ----------------------------------------------------------------------------
// abts_pkg
// Types and constants shared by the alarm burst tone sequencer.
// ----------------------------------------------------------------------------
package abts_pkg;

    localparam int PULSE_W = 8;
    localparam int MS_W    = 16;
    localparam int PRIO_W  = 2;
    localparam int IDX_W   = 3;

    typedef logic [PULSE_W-1:0] t_pulses;
    typedef logic [MS_W-1:0]    t_ms;
    typedef logic [PRIO_W-1:0]  t_prio;

    // Configuration register indexes
    typedef enum logic [IDX_W-1:0] {
        CFG_PULSES_HIGH    = 3'd0,
        CFG_PULSES_MEDIUM  = 3'd1,
        CFG_PULSES_LOW     = 3'd2,
        CFG_PERIOD_HIGH    = 3'd3,
        CFG_PERIOD_MEDIUM  = 3'd4,
        CFG_PERIOD_LOW     = 3'd5,
        CFG_PULSE_ON       = 3'd6,
        CFG_PULSE_GAP      = 3'd7
    } t_cfg_idx;

    // Priority codes; the unused code behaves as low
    localparam t_prio PRIO_LOW    = 2'd0;
    localparam t_prio PRIO_MEDIUM = 2'd1;
    localparam t_prio PRIO_HIGH   = 2'd2;

    localparam t_pulses RST_PULSES_HIGH   = 8'd10;
    localparam t_pulses RST_PULSES_MEDIUM = 8'd3;
    localparam t_pulses RST_PULSES_LOW    = 8'd2;
    localparam t_ms     RST_PERIOD_HIGH   = 16'd5000;
    localparam t_ms     RST_PERIOD_MEDIUM = 16'd10000;
    localparam t_ms     RST_PERIOD_LOW    = 16'd20000;
    localparam t_ms     RST_PULSE_ON      = 16'd150;
    localparam t_ms     RST_PULSE_GAP     = 16'd100;

    typedef struct packed {
        t_pulses pulses_high;
        t_pulses pulses_medium;
        t_pulses pulses_low;
        t_ms     period_high;
        t_ms     period_medium;
        t_ms     period_low;
        t_ms     pulse_on;
        t_ms     pulse_gap;
    } t_cfg;

endpackage

>>> src/abts_if.sv
// ----------------------------------------------------------------------------
// abts interfaces
// Valid/ready channels for tick items, result items and register writes.
// ----------------------------------------------------------------------------
interface abts_in_if
    import abts_pkg::*;
();
    logic  valid;
    logic  ready;
    logic  audio_required;
    t_prio alarm_priority;
    modport source (output valid, audio_required, alarm_priority, input ready);
    modport sink   (input valid, audio_required, alarm_priority, output ready);
endinterface

interface abts_out_if
    import abts_pkg::*;
();
    logic    valid;
    logic    ready;
    logic    tone_on;
    t_pulses pulses_remaining;
    modport source (output valid, tone_on, pulses_remaining, input ready);
    modport sink   (input valid, tone_on, pulses_remaining, output ready);
endinterface

interface abts_cfg_if
    import abts_pkg::*;
();
    logic     valid;
    logic     ready;
    t_cfg_idx index;
    t_ms      data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> src/alarm_burst_tone_sequencer_unit.sv
// One tick item per clock: each millisecond tick is taken into an input
// register, the burst pattern state is updated in a single pass of compare
// and count logic, and the result item appears in an output register; a new
// tick is accepted every cycle as long as the result side keeps taking
// items. Register writes take effect on the next cycle; after reset the
// registers hold the default pulse counts and periods and the pattern is
// silent at low priority.
// ----------------------------------------------------------------------------
// alarm_burst_tone_sequencer_unit
// Alarm tone burst pattern generator, top level.
// ----------------------------------------------------------------------------
module alarm_burst_tone_sequencer_unit
    import abts_pkg::*;
#(
    parameter int TIME_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    abts_cfg_if.sink    i_cfg,
    abts_in_if.sink     i_in,
    abts_out_if.source  o_out
);

    t_cfg cfg;

    abts_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    abts_core #(
        .TIME_BITS (TIME_BITS)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_in    (i_in),
        .o_out   (o_out)
    );

endmodule

>>> src/abts_cfg_regs.sv
// ----------------------------------------------------------------------------
// abts_cfg_regs
// Configuration register file; always ready, narrow registers take low bits.
// ----------------------------------------------------------------------------
module abts_cfg_regs
    import abts_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    abts_cfg_if.sink    i_cfg,
    output t_cfg        o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_PULSES_HIGH:   n_cfg.pulses_high   = i_cfg.data[PULSE_W-1:0];
                CFG_PULSES_MEDIUM: n_cfg.pulses_medium = i_cfg.data[PULSE_W-1:0];
                CFG_PULSES_LOW:    n_cfg.pulses_low    = i_cfg.data[PULSE_W-1:0];
                CFG_PERIOD_HIGH:   n_cfg.period_high   = i_cfg.data;
                CFG_PERIOD_MEDIUM: n_cfg.period_medium = i_cfg.data;
                CFG_PERIOD_LOW:    n_cfg.period_low    = i_cfg.data;
                CFG_PULSE_ON:      n_cfg.pulse_on      = i_cfg.data;
                CFG_PULSE_GAP:     n_cfg.pulse_gap     = i_cfg.data;
                default:           n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{pulses_high:   RST_PULSES_HIGH,
                       pulses_medium: RST_PULSES_MEDIUM,
                       pulses_low:    RST_PULSES_LOW,
                       period_high:   RST_PERIOD_HIGH,
                       period_medium: RST_PERIOD_MEDIUM,
                       period_low:    RST_PERIOD_LOW,
                       pulse_on:      RST_PULSE_ON,
                       pulse_gap:     RST_PULSE_GAP};
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

>>> src/abts_core.sv
// ----------------------------------------------------------------------------
// abts_core
// Input register, pattern state update and result register.
// ----------------------------------------------------------------------------
`include "alarm_burst_tone_sequencer_unit_defines.svh"

module abts_core
    import abts_pkg::*;
#(
    parameter int TIME_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    abts_in_if.sink     i_in,
    abts_out_if.source  o_out
);

    localparam int CMP_W = (TIME_BITS > MS_W) ? TIME_BITS : MS_W;
    localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

    // input stage
    logic  r_in_valid;
    logic  r_in_audio;
    t_prio r_in_prio;

    // pattern state
    logic [TIME_BITS-1:0] r_elapsed, n_elapsed;
    t_pulses              r_count, n_count;
    logic                 r_tone, n_tone;
    t_prio                r_prev, n_prev;

    // result stage
    logic    r_out_valid;
    logic    r_out_tone;
    t_pulses r_out_pulses;

    logic out_free;
    logic adv;

    assign out_free   = !r_out_valid || o_out.ready;
    assign adv        = r_in_valid && out_free;
    assign i_in.ready = !r_in_valid || out_free;

    assign o_out.valid            = r_out_valid;
    assign o_out.tone_on          = r_out_tone;
    assign o_out.pulses_remaining = r_out_pulses;

    always_comb begin
        logic [TIME_BITS-1:0] e;
        t_pulses              pc;
        logic                 tl;
        t_pulses              pulses;
        t_ms                  period;
        t_ms                  slot;
        logic                 done;

        e      = r_elapsed;
        pc     = r_count;
        tl     = r_tone;
        pulses = i_cfg.pulses_low;
        period = i_cfg.period_low;
        slot   = i_cfg.pulse_gap;
        done   = 1'b0;

        if (!r_in_audio) begin
            e  = '0;
            pc = '0;
            tl = 1'b0;
        end else begin
            if (e != TIME_MAX)
                e = e + 1'b1;
            if (r_in_prio != r_prev) begin
                e  = '0;
                pc = '0;
                tl = 1'b0;
            end
            if (r_in_prio == PRIO_HIGH) begin
                pulses = i_cfg.pulses_high;
                period = i_cfg.period_high;
            end else if (r_in_prio == PRIO_MEDIUM) begin
                pulses = i_cfg.pulses_medium;
                period = i_cfg.period_medium;
            end
            // silent wait until the burst period, then load the burst
            if (pc == '0) begin
                if (CMP_W'(e) < CMP_W'(period)) begin
                    done = 1'b1;
                end else begin
                    pc = pulses;
                    e  = '0;
                    tl = 1'b0;
                    if (pc == '0)
                        done = 1'b1;
                end
            end
            if (!done) begin
                slot = tl ? i_cfg.pulse_on : i_cfg.pulse_gap;
                if (CMP_W'(e) >= CMP_W'(slot)) begin
                    e  = '0;
                    tl = !tl;
                    if (!tl && pc != '0)
                        pc = pc - 1'b1;
                end
            end
        end

        n_elapsed = e;
        n_count   = pc;
        n_tone    = tl;
        n_prev    = r_in_prio;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_elapsed   <= '0;
            r_count     <= '0;
            r_tone      <= 1'b0;
            r_prev      <= PRIO_LOW;
        end else begin
            if (i_in.valid && i_in.ready)
                r_in_valid <= 1'b1;
            else if (adv)
                r_in_valid <= 1'b0;
            if (out_free)
                r_out_valid <= r_in_valid;
            if (adv) begin
                r_elapsed <= n_elapsed;
                r_count   <= n_count;
                r_tone    <= n_tone;
                r_prev    <= n_prev;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_audio <= i_in.audio_required;
            r_in_prio  <= i_in.alarm_priority;
        end
        if (adv) begin
            r_out_tone   <= n_tone;
            r_out_pulses <= n_count;
        end
    end

    // tone only sounds inside a burst with pulses left
    `ABTS_ASSERT_IMP(a_tone_has_pulse, r_tone, r_count != '0)
    // pattern state moves only with an item
    `ABTS_ASSERT_NXT(a_state_hold, !adv,
        $stable(r_count) && $stable(r_tone) && $stable(r_elapsed))
    // audio off silences and clears the burst
    `ABTS_ASSERT_NXT(a_audio_off, adv && !r_in_audio,
        !r_tone && r_count == '0 && r_elapsed == '0)
    // an item leaving the input stage always lands in the result stage
    `ABTS_ASSERT_NXT(a_result_follows, adv, r_out_valid)

endmodule
